// ===== hdl/tcw_pkg.sv =====
// shared types and constants for the text console cell writer
`timescale 1ns / 1ps

package tcw_pkg;

  // default screen geometry
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // operation codes
  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_SETPOS = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // control characters
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_BLANK   = 8'd32;

  // attribute after reset and the blank cell it gives
  localparam logic [7:0]  RESET_ATTR = 8'd7;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

  // tab stops fall on multiples of four
  localparam logic [7:0] TAB_STEP = 8'd4;
  localparam logic [7:0] TAB_MASK = ~8'd3;

  // result field widths
  localparam int ROW_OW = 5;
  localparam int COL_OW = 7;
  localparam int LIN_OW = 11;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] target_row;
    logic [7:0] target_col;
  } in_req_t;

  typedef struct packed {
    logic [ROW_OW-1:0] cursor_row;
    logic [COL_OW-1:0] cursor_col;
    logic [LIN_OW-1:0] cursor_linear;
    logic [15:0]       cell_value;
  } out_rsp_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcw_lin_unit.sv =====
// shared row and column to linear cell index unit
`timescale 1ns / 1ps

module tcw_lin_unit #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic [$clog2(ROWS)-1:0]      row_i,
  input  logic [$clog2(COLS)-1:0]      col_i,
  output logic [$clog2(ROWS*COLS)-1:0] lin_o
);

  localparam int AW = $clog2(ROWS * COLS);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  // row times line length plus column
  assign lin_o = AW'(row_i) * COLS_A + AW'(col_i);

endmodule

// ===== hdl/text_console_cell_writer_core.sv =====
// text console engine: cursor sequencer over a cell store and a shared index unit
//
// Usage: present a request on in_req and raise start; it is taken at a clock edge
// where start is high and busy is low. busy stays high while the request is worked.
// Every request yields one result on out_rsp, marked by a one-cycle out_valid
// strobe; the receiver cannot stall, so it must take the result in that cycle.
// cfg_we with cfg_wdata sets the attribute byte for new and blanked cells; write
// it only while busy is low and no result is pending.
// Newline, return, set position and far tab move the cursor; a printable
// byte writes one cell, a tab writes blanks up to its stop, read cell fetches one
// cell and clear screen blanks every cell. Any line feed past the last row adds a
// scroll. The cell store has one write and one read port; scroll copies each cell
// by a read, then a write, and blanking writes one cell per cycle.
// After reset a clearing pass fills every cell with a blank of attribute 7 and
// homes the cursor; busy is high during it while configuration writes are still
// taken. A new request can be taken in the cycle its predecessor's result is
// strobed.
`timescale 1ns / 1ps

module text_console_cell_writer_core
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int N  = ROWS * COLS;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = $clog2(N);

  localparam logic [RW-1:0] ROW_LAST     = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST     = CW'(COLS - 1);
  localparam logic [AW-1:0] IDX_LAST     = AW'(N - 1);
  localparam logic [AW-1:0] IDX_SCR_LAST = AW'(N - COLS - 1);
  localparam logic [AW-1:0] IDX_BOTTOM   = AW'(N - COLS);
  localparam logic [AW-1:0] COLS_A       = AW'(COLS);
  localparam logic [7:0]    ROWS_B       = 8'(ROWS);
  localparam logic [7:0]    COLS_B       = 8'(COLS);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_PUT    = 9'b000000100,
    S_TAB    = 9'b000001000,
    S_SCR_RD = 9'b000010000,
    S_SCR_WR = 9'b000100000,
    S_FILL   = 9'b001000000,
    S_READ   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [1:0]      op_r, op_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic [RW-1:0]   trow_r, trow_nxt;
  logic [CW-1:0]   tcol_r, tcol_nxt;
  logic [7:0]      tab_stop_r, tab_stop_nxt;
  out_rsp_t        out_rsp_r, out_rsp_nxt;

  logic            accept;
  logic [RW-1:0]   row_clamp;
  logic [CW-1:0]   col_clamp;
  logic [7:0]      stop_calc;
  logic [15:0]     blank;
  logic [RW-1:0]   lin_row;
  logic [CW-1:0]   lin_col;
  logic [AW-1:0]   lin;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;
  logic [31:0]     row_ext;
  logic [31:0]     col_ext;
  logic [31:0]     lin_ext;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // clamp targets to the screen
  assign row_clamp = (in_req.target_row >= ROWS_B) ? ROW_LAST : in_req.target_row[RW-1:0];
  assign col_clamp = (in_req.target_col >= COLS_B) ? COL_LAST : in_req.target_col[CW-1:0];

  // next tab stop from the current column
  assign stop_calc = (8'(col_r) + TAB_STEP) & TAB_MASK;
  assign blank     = {attr_r, CH_BLANK};

  // shared index unit: read target while reading, cursor otherwise
  assign lin_row = (state_r == S_READ) ? trow_r : row_r;
  assign lin_col = (state_r == S_READ) ? tcol_r : col_r;

  tcw_lin_unit #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_lin (
    .row_i (lin_row),
    .col_i (lin_col),
    .lin_o (lin)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (N)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // store port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = blank;
    ram_raddr = lin;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lin;
        ram_wdata = {attr_r, ch_r};
      end
      S_TAB: begin
        ram_we    = 1'b1;
        ram_waddr = lin;
      end
      S_SCR_RD: begin
        ram_raddr = idx_r + COLS_A;
      end
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result fields cut to their widths
  assign row_ext = 32'(row_r);
  assign col_ext = 32'(col_r);
  assign lin_ext = 32'(lin);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    attr_nxt      = cfg_we ? cfg_wdata : attr_r;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    trow_nxt      = trow_r;
    tcol_nxt      = tcol_r;
    tab_stop_nxt  = tab_stop_r;
    out_rsp_nxt   = out_rsp_r;

    case (state_r)
      // blank every cell after reset
      S_INIT: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // take a request and decode it
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_req.operation;
          ch_nxt    = in_req.char_code;
          trow_nxt  = row_clamp;
          tcol_nxt  = col_clamp;
          state_nxt = S_DONE;
          case (in_req.operation)
            OP_PUT: begin
              if (in_req.char_code == CH_RETURN) begin
                col_nxt = '0;
              end else if (in_req.char_code == CH_NEWLINE ||
                           (in_req.char_code == CH_TAB && stop_calc >= COLS_B)) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  idx_nxt   = '0;
                  state_nxt = S_SCR_RD;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end else if (in_req.char_code == CH_TAB) begin
                tab_stop_nxt = stop_calc;
                state_nxt    = S_TAB;
              end else begin
                state_nxt = S_PUT;
              end
            end
            OP_SETPOS: begin
              row_nxt = row_clamp;
              col_nxt = col_clamp;
            end
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_READ: begin
              state_nxt = S_READ;
            end
            default: begin
            end
          endcase
        end
      end

      // one printable cell, then advance and wrap
      S_PUT: begin
        state_nxt = S_DONE;
        if (col_r == COL_LAST) begin
          col_nxt = '0;
          if (row_r == ROW_LAST) begin
            idx_nxt   = '0;
            state_nxt = S_SCR_RD;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      // blanks up to the tab stop
      S_TAB: begin
        col_nxt = col_r + CW'(1);
        if ((8'(col_r) + 8'd1) == tab_stop_r) begin
          state_nxt = S_DONE;
        end
      end

      // scroll: fetch the cell one row below
      S_SCR_RD: begin
        state_nxt = S_SCR_WR;
      end

      // scroll: store it one row up
      S_SCR_WR: begin
        if (idx_r == IDX_SCR_LAST) begin
          idx_nxt   = IDX_BOTTOM;
          state_nxt = S_FILL;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SCR_RD;
        end
      end

      // blank cells through the end of the store
      S_FILL: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      // read address issued, data arrives next cycle
      S_READ: begin
        state_nxt = S_DONE;
      end

      // build the result
      S_DONE: begin
        out_rsp_nxt.cursor_row    = row_ext[ROW_OW-1:0];
        out_rsp_nxt.cursor_col    = col_ext[COL_OW-1:0];
        out_rsp_nxt.cursor_linear = lin_ext[LIN_OW-1:0];
        out_rsp_nxt.cell_value    = (op_r == OP_READ) ? ram_rdata : 16'd0;
        out_valid_nxt             = 1'b1;
        state_nxt                 = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    trow_r     <= trow_nxt;
    tcol_r     <= tcol_nxt;
    tab_stop_r <= tab_stop_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  // a taken request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request accepted");

  // results come only as isolated strobes while the block is idle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe repeated or while busy");

  // cursor always stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_LAST) && (col_r <= COL_LAST))
    else $error("cursor off screen");

  // the tab loop never runs past its stop
  a_tab_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAB) |-> (8'(col_r) < tab_stop_r))
    else $error("tab fill past stop");

endmodule
